>>> rtl/asc_pkg.sv
// shared types and constants for the age stream classifier
`timescale 1ns / 1ps

package asc_pkg;

  localparam int unsigned TimeW   = 64;
  localparam int unsigned GranW   = 32;
  localparam int unsigned CountW  = 5;
  localparam int unsigned BaseW   = 8;
  localparam int unsigned StreamW = 9;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned DivCntW = 6;

  // last step of the bit-serial divider
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(TimeW - 1);

  // configuration register indices
  localparam logic [CfgIdxW-1:0] CfgStreamCount = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgAgeGran     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCreatedOnly = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgStreamBase  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgVictimLimit = 3'd4;

  // request codes
  localparam logic FuncClassify = 1'b0;
  localparam logic FuncVictim   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MAP,
    ST_CRD,
    ST_CWR,
    ST_SRD,
    ST_SCHK,
    ST_RES
  } asc_state_e;

endpackage

>>> rtl/age_stream_classifier_unit.sv
// age stream classifier: bit-serial age divider, stream table and victim scan
// classify: an accepted beat runs 64 divider steps, then the map, table read and table write states, to the result
// victim: each scanned stream takes a table read and a check; outside created-only mode the result is a miss, no scan
// one item at a time: a new beat is taken only when idle, and the next beat is taken
// while a result still waits at the output
// reset clears the configuration to its defaults and all stream valid bits at once
`timescale 1ns / 1ps

module age_stream_classifier_unit #(
  parameter int unsigned MAX_STREAMS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [asc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [asc_pkg::TimeW-1:0]     cfg_data_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic [asc_pkg::TimeW-1:0]     now_time_i,
  input  logic [asc_pkg::TimeW-1:0]     created_time_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [asc_pkg::StreamW-1:0]   stream_number_o,
  output logic                          found_o
);

  import asc_pkg::*;

  localparam int unsigned IW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
  localparam int unsigned CW = $clog2(MAX_STREAMS + 1);
  localparam logic [7:0]  MaxCnt = 8'(MAX_STREAMS);

  // configuration registers
  logic [CountW-1:0] stream_count_q;
  logic [GranW-1:0]  gran_q;
  logic              mode_q;
  logic [BaseW-1:0]  base_q;
  logic [TimeW-1:0]  limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_count_q <= CountW'(16);
      gran_q         <= GranW'(1);
      mode_q         <= 1'b0;
      base_q         <= '0;
      limit_q        <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgStreamCount: stream_count_q <= cfg_data_i[CountW-1:0];
        CfgAgeGran:     gran_q         <= cfg_data_i[GranW-1:0];
        CfgCreatedOnly: mode_q         <= cfg_data_i[0];
        CfgStreamBase:  base_q         <= cfg_data_i[BaseW-1:0];
        CfgVictimLimit: limit_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective stream count, forced into 1..MAX_STREAMS
  logic [7:0]    cnt8;
  logic [CW-1:0] count;

  always_comb begin
    cnt8 = {3'b000, stream_count_q};
    if (cnt8 == 8'd0) begin
      cnt8 = 8'd1;
    end else if (cnt8 > MaxCnt) begin
      cnt8 = MaxCnt;
    end
    count = cnt8[CW-1:0];
  end

  asc_state_e state_q, state_d;

  logic [TimeW-1:0]   now_q, created_q;
  logic [TimeW-1:0]   dvd_q;      // dividend, quotient shifts in from the bottom
  logic [GranW-1:0]   rem_q;
  logic [CW-1:0]      qmod_q;     // running quotient mod count
  logic [DivCntW-1:0] div_cnt_q;
  logic [CW-1:0]      idx_q;
  logic [IW-1:0]      stream_q;
  logic [MAX_STREAMS-1:0] valid_q;
  logic [StreamW-1:0] res_num_q;
  logic               res_found_q;
  logic               out_valid_q;
  logic [StreamW-1:0] out_num_q;
  logic               out_found_q;

  logic [TimeW-1:0] mem_q [MAX_STREAMS];
  logic [TimeW-1:0] rd_data_q;

  // divider step
  logic [GranW:0] rem_sh;
  logic           q_bit;
  logic [GranW:0] rem_sub;
  logic [CW:0]    qmod_sh;
  logic [CW-1:0]  qmod_d;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[TimeW-1]};
    q_bit   = (rem_sh >= {1'b0, gran_q});
    rem_sub = q_bit ? (rem_sh - {1'b0, gran_q}) : rem_sh;
    qmod_sh = {qmod_q, q_bit};
    qmod_d  = (qmod_sh >= {1'b0, count}) ? CW'(qmod_sh - {1'b0, count}) : qmod_sh[CW-1:0];
  end

  // quotient to stream
  logic          q_ge;
  logic [CW-1:0] stream_sel;

  always_comb begin
    q_ge = (dvd_q[CW-1:0] >= count);
    if (TimeW > CW) begin
      q_ge = q_ge || (dvd_q[TimeW-1:CW] != '0);
    end
    if (mode_q) begin
      stream_sel = qmod_q;
    end else if (q_ge) begin
      stream_sel = count - CW'(1);
    end else begin
      stream_sel = dvd_q[CW-1:0];
    end
  end

  // table checks
  logic [IW-1:0]    scan_idx;
  logic [TimeW-1:0] victim_age;
  logic             scan_hit;
  logic             scan_end;
  logic             take_new;

  assign scan_idx   = idx_q[IW-1:0];
  assign victim_age = now_q - rd_data_q;
  assign scan_hit   = valid_q[scan_idx] && (victim_age >= limit_q);
  assign scan_end   = (idx_q >= count);
  assign take_new   = !valid_q[stream_q] || (rd_data_q == '0) || (created_q < rd_data_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (func_i == FuncClassify) begin
            state_d = ST_DIV;
          end else if (mode_q) begin
            state_d = ST_SRD;
          end else begin
            state_d = ST_RES;
          end
        end
      end
      ST_DIV:  if (div_cnt_q == DivLast) state_d = ST_MAP;
      ST_MAP:  state_d = ST_CRD;
      ST_CRD:  state_d = ST_CWR;
      ST_CWR:  state_d = ST_RES;
      ST_SRD:  state_d = scan_end ? ST_RES : ST_SCHK;
      ST_SCHK: state_d = scan_hit ? ST_RES : ST_SRD;
      ST_RES:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  logic          in_take;
  logic          mem_we;
  logic [IW-1:0] rd_addr;
  logic          out_load;

  always_comb begin
    in_take  = 1'b0;
    mem_we   = 1'b0;
    rd_addr  = scan_idx;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: in_take  = in_valid_i;
      ST_CRD:  rd_addr  = stream_q;
      ST_CWR:  mem_we   = take_new;
      ST_RES:  out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CWR) begin
        valid_q[stream_q] <= 1'b1;
      end else if (state_q == ST_SCHK && scan_hit) begin
        valid_q[scan_idx] <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          now_q       <= now_time_i;
          created_q   <= created_time_i;
          dvd_q       <= mode_q ? created_time_i : (now_time_i - created_time_i);
          rem_q       <= '0;
          qmod_q      <= '0;
          div_cnt_q   <= '0;
          idx_q       <= '0;
          res_num_q   <= '0;
          res_found_q <= 1'b0;
        end
      end
      ST_DIV: begin
        rem_q     <= rem_sub[GranW-1:0];
        dvd_q     <= {dvd_q[TimeW-2:0], q_bit};
        qmod_q    <= qmod_d;
        div_cnt_q <= div_cnt_q + DivCntW'(1);
      end
      ST_MAP: stream_q <= stream_sel[IW-1:0];
      ST_CWR: begin
        res_num_q   <= {1'b0, base_q} + {{(StreamW - IW){1'b0}}, stream_q};
        res_found_q <= 1'b1;
      end
      ST_SCHK: begin
        if (scan_hit) begin
          res_num_q   <= {1'b0, base_q} + {{(StreamW - IW){1'b0}}, scan_idx};
          res_found_q <= 1'b1;
        end else begin
          idx_q <= idx_q + CW'(1);
        end
      end
      ST_RES: begin
        if (out_load) begin
          out_num_q   <= res_num_q;
          out_found_q <= res_found_q;
        end
      end
      default: ;
    endcase
  end

  // oldest creation time per stream
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[stream_q] <= created_q;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  assign out_valid_o     = out_valid_q;
  assign stream_number_o = out_num_q;
  assign found_o         = out_found_q;

  // a classify beat always starts the divider
  a_classify_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && func_i == FuncClassify) |=> state_q == ST_DIV)
    else $error("classify beat did not start the divider");

  // a stream that was just updated is marked valid
  a_stream_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CWR) |=> valid_q[stream_q])
    else $error("updated stream not marked valid");

  // a miss carries stream number zero
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> stream_number_o == '0)
    else $error("miss result with non-zero stream number");

  // results only leave after the sequencer has finished an item
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_RES)
    else $error("result appeared without a finished item");

endmodule

>>> sim/age_stream_classifier_unit_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the age stream classifier: directed and random gc requests, scoreboard
module age_stream_classifier_unit_tb;
  import asc_pkg::*;

  localparam int unsigned MaxStreams = 16;
  localparam int unsigned WaitMax    = 13;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned RandPhases = 10;
  localparam int unsigned PhaseItems = 80;

  typedef logic [TimeW-1:0] stamp_t;

  typedef struct {
    logic   func;
    stamp_t now_time;
    stamp_t created_time;
    bit     hold;
  } gc_req_t;

  typedef struct {
    logic [StreamW-1:0] stream_number;
    logic               found;
  } stream_res_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i      = '0;
  stamp_t             cfg_data_i     = '0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic               func_i         = FuncClassify;
  stamp_t             now_time_i     = '0;
  stamp_t             created_time_i = '0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic [StreamW-1:0] stream_number_o;
  logic               found_o;

  // shadow of the configuration and the stream table
  logic [CountW-1:0] cfg_count        = CountW'(16);
  logic [GranW-1:0]  cfg_gran         = GranW'(1);
  logic              cfg_created_only = 1'b0;
  logic [BaseW-1:0]  cfg_base         = '0;
  stamp_t            cfg_limit        = '0;
  bit [TimeW-1:0]    stream_oldest [MaxStreams];
  bit                stream_live   [MaxStreams];

  gc_req_t     req_q[$];
  stream_res_t expected_streams[$];

  int unsigned sent_cnt     = 0;
  int unsigned got_cnt      = 0;
  int unsigned pushed_cnt   = 0;
  int unsigned fail_cnt     = 0;
  int unsigned quiet_cycles = 0;
  int unsigned in_gap       = 0;
  int unsigned out_stall    = 0;
  bit          gaps_on      = 1'b1;
  gc_req_t     in_beat;
  stream_res_t mon_want;

  age_stream_classifier_unit #(
    .MAX_STREAMS(MaxStreams)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .now_time_i     (now_time_i),
    .created_time_i (created_time_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .stream_number_o(stream_number_o),
    .found_o        (found_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned streams_in_use();
    if (cfg_count == 0) return 1;
    if (cfg_count > MaxStreams) return MaxStreams;
    return cfg_count;
  endfunction

  function automatic stream_res_t predict_stream(gc_req_t rq);
    stream_res_t res;
    stamp_t      age;
    stamp_t      quo;
    int unsigned cnt;
    res.stream_number = '0;
    res.found         = 1'b0;
    cnt               = streams_in_use();
    if (rq.func == FuncClassify) begin
      age = cfg_created_only ? rq.created_time : rq.now_time - rq.created_time;
      // a zero divisor gives an all-ones quotient
      quo = (cfg_gran == 0) ? '1 : age / cfg_gran;
      if (quo >= cnt) quo = cfg_created_only ? quo % cnt : stamp_t'(cnt - 1);
      if (!stream_live[quo] || stream_oldest[quo] == 0 || rq.created_time < stream_oldest[quo])
        stream_oldest[quo] = rq.created_time;
      stream_live[quo]  = 1'b1;
      res.stream_number = StreamW'(quo) + StreamW'(cfg_base);
      res.found         = 1'b1;
    end else if (cfg_created_only) begin
      for (int i = 0; i < cnt; i++) begin
        if (!res.found && stream_live[i] && rq.now_time - stream_oldest[i] >= cfg_limit) begin
          stream_live[i]    = 1'b0;
          res.stream_number = StreamW'(i) + StreamW'(cfg_base);
          res.found         = 1'b1;
        end
      end
    end
    return res;
  endfunction

  function automatic int unsigned draw_wait();
    return gaps_on ? $urandom_range(0, WaitMax) : 0;
  endfunction

  function automatic stamp_t rand_stamp();
    case ($urandom_range(0, 3))
      0: return stamp_t'($urandom_range(0, 64));
      1: return '1 - stamp_t'($urandom_range(0, 64));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic gc_req_t random_req();
    gc_req_t     rq;
    stamp_t      age;
    int unsigned cnt;
    int unsigned pick;
    cnt             = streams_in_use();
    rq.hold         = ($urandom_range(0, 49) == 0);
    rq.func         = ($urandom_range(0, 3) == 0) ? FuncVictim : FuncClassify;
    rq.now_time     = rand_stamp();
    rq.created_time = rand_stamp();
    if (rq.func == FuncVictim) begin
      // aim now at the age limit of a live stream, one either side
      pick = $urandom_range(0, MaxStreams - 1);
      if (stream_live[pick] && $urandom_range(0, 3) != 0)
        rq.now_time = stream_oldest[pick] + cfg_limit + stamp_t'($urandom_range(0, 2)) - 1;
    end else if ($urandom_range(0, 15) == 0) begin
      rq.created_time = '0;
    end else if ($urandom_range(0, 4) != 0) begin
      // age aimed at a stream from zero up to two above the count
      age = stamp_t'($urandom_range(0, cnt + 2)) * cfg_gran;
      if (cfg_gran != 0) age += stamp_t'($urandom_range(0, cfg_gran - 1));
      if (cfg_created_only)
        rq.created_time = age + stamp_t'($urandom_range(0, 3)) * cnt * cfg_gran;
      else
        rq.now_time = rq.created_time + age;
    end
    return rq;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, stamp_t data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CfgStreamCount: cfg_count        = data[CountW-1:0];
      CfgAgeGran:     cfg_gran         = data[GranW-1:0];
      CfgCreatedOnly: cfg_created_only = data[0];
      CfgStreamBase:  cfg_base         = data[BaseW-1:0];
      CfgVictimLimit: cfg_limit        = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // junk in the bits above the register width
  function automatic stamp_t with_junk(stamp_t value, int unsigned width);
    stamp_t keep;
    keep = (stamp_t'(1) << width) - 1;
    return ({$urandom, $urandom} & ~keep) | (value & keep);
  endfunction

  task automatic random_config();
    int unsigned cnt;
    int unsigned gran;
    int unsigned base;
    stamp_t      lim;
    case ($urandom_range(0, 4))
      0: cnt = 0;
      1: cnt = 1;
      2: cnt = 16;
      3: cnt = $urandom_range(17, 31);
      default: cnt = $urandom_range(1, 16);
    endcase
    case ($urandom_range(0, 5))
      0: gran = 0;
      1: gran = 1;
      2: gran = 32'hFFFF_FFFF;
      3: gran = $urandom;
      default: gran = $urandom_range(1, 1 << $urandom_range(0, 20));
    endcase
    case ($urandom_range(0, 3))
      0: base = 0;
      1: base = 255;
      default: base = $urandom_range(0, 255);
    endcase
    case ($urandom_range(0, 4))
      0: lim = '0;
      1: lim = '1;
      2: lim = {$urandom, $urandom};
      default: lim = stamp_t'($urandom_range(0, 1 << $urandom_range(0, 30)));
    endcase
    write_reg(CfgStreamCount, with_junk(stamp_t'(cnt), CountW));
    write_reg(CfgAgeGran, with_junk(stamp_t'(gran), GranW));
    write_reg(CfgCreatedOnly, with_junk(stamp_t'($urandom_range(0, 1)), 1));
    write_reg(CfgStreamBase, with_junk(stamp_t'(base), BaseW));
    write_reg(CfgVictimLimit, lim);
  endtask

  task automatic wait_room();
    @(negedge clk_i);
    while (req_q.size() >= 1) @(negedge clk_i);
  endtask

  task automatic push_req(gc_req_t rq);
    req_q.push_back(rq);
    pushed_cnt++;
  endtask

  task automatic send(logic func, stamp_t now_t, stamp_t created_t);
    gc_req_t rq;
    rq.func         = func;
    rq.now_time     = now_t;
    rq.created_time = created_t;
    rq.hold         = 1'b0;
    wait_room();
    push_req(rq);
  endtask

  task automatic wait_drained();
    while (sent_cnt != pushed_cnt || got_cnt != sent_cnt) @(posedge clk_i);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_streams.push_back(predict_stream(in_beat));
        sent_cnt <= sent_cnt + 1;
        in_gap = draw_wait();
      end
      if (!in_valid_i || in_ready_o) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (req_q.size() != 0 &&
                     !(req_q[0].hold && (in_valid_i || got_cnt != sent_cnt))) begin
          // a held beat waits until every outstanding result is back
          in_beat = req_q.pop_front();
          func_i         <= in_beat.func;
          now_time_i     <= in_beat.now_time;
          created_time_i <= in_beat.created_time;
          in_valid_i     <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and scoreboard
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_streams.size() == 0) begin
          $error("result beat with nothing outstanding: stream_number %0d found %0d",
                 stream_number_o, found_o);
          fail_cnt++;
        end else begin
          mon_want = expected_streams.pop_front();
          if (stream_number_o !== mon_want.stream_number) begin
            $error("stream_number: expected %0d, got %0d", mon_want.stream_number,
                   stream_number_o);
            fail_cnt++;
          end
          if (found_o !== mon_want.found) begin
            $error("found: expected %0d, got %0d", mon_want.found, found_o);
            fail_cnt++;
          end
        end
        got_cnt <= got_cnt + 1;
        out_stall = draw_wait();
      end else if (out_valid_o && out_stall != 0) begin
        out_stall--;
      end
      out_ready_i <= (out_stall == 0);
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("age_stream_classifier_unit verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    gc_req_t rq;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset configuration: plain ages, clamping, victim refused
    send(FuncClassify, 64'd100, 64'd100);
    send(FuncClassify, 64'd0, 64'd0);
    send(FuncClassify, '1, 64'd0);
    send(FuncClassify, 64'd0, '1);
    send(FuncVictim, '1, 64'd0);
    wait_drained();

    // created-only: wrapping, zero entries, victim scan from the bottom
    write_reg(CfgCreatedOnly, 64'd1);
    write_reg(CfgVictimLimit, 64'd0);
    write_reg(CfgStreamBase, 64'd0);
    send(FuncClassify, 64'd0, 64'd5);
    send(FuncClassify, 64'd0, '1);
    send(FuncClassify, 64'd0, 64'd17);
    send(FuncClassify, 64'd0, 64'd0);
    send(FuncVictim, 64'd0, 64'd0);
    send(FuncVictim, 64'd0, 64'd0);
    wait_drained();

    // count of zero, zero divisor, top base, top limit, unused indexes
    write_reg(CfgStreamCount, 64'd0);
    write_reg(CfgAgeGran, 64'd0);
    write_reg(CfgStreamBase, 64'd255);
    write_reg(CfgVictimLimit, '1);
    for (int k = 1; k <= 3; k++) write_reg(CfgVictimLimit + CfgIdxW'(k), {$urandom, $urandom});
    send(FuncClassify, 64'd0, 64'd123);
    send(FuncVictim, 64'd122, 64'd0);
    send(FuncVictim, 64'd0, 64'd0);
    wait_drained();

    // count above the maximum, widest divisor, back to plain ages
    write_reg(CfgStreamCount, 64'd31);
    write_reg(CfgAgeGran, 64'hFFFF_FFFF);
    write_reg(CfgCreatedOnly, 64'd0);
    send(FuncClassify, '1, 64'd0);
    send(FuncClassify, 64'hFFFF_FFFF, 64'd0);
    send(FuncVictim, '1, 64'd0);
    wait_drained();

    write_reg(CfgStreamCount, 64'd1);
    send(FuncClassify, {$urandom, $urandom}, {$urandom, $urandom});
    send(FuncClassify, '1, 64'd1);
    wait_drained();

    for (int p = 0; p < RandPhases; p++) begin
      random_config();
      @(negedge clk_i);
      gaps_on = (p % 4 != 1);
      for (int n = 0; n < PhaseItems; n++) begin
        wait_room();
        rq = random_req();
        if (n == PhaseItems / 2) rq.hold = 1'b1;
        push_req(rq);
      end
      wait_drained();
    end

    repeat (100) @(posedge clk_i);
    if (fail_cnt == 0 && expected_streams.size() == 0) begin
      $display("age_stream_classifier_unit verification clean");
    end else begin
      $display("age_stream_classifier_unit verification failed");
    end
    $finish;
  end

endmodule
